// ===== rtl/pts_pkg.sv =====
// Shared types and codes of the periodic task tick scheduler.
package pts_pkg;

  // Number of task slots.
  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // Field widths.
  localparam int OP_W    = 3;
  localparam int INDEX_W = 3;
  localparam int TIME_W  = 16;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  // Input operations.
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUSPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_RESUME  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd2;

  // Command status codes.
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_IN_USE     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_HANDLER = 2'd2;

  // Table write operations.
  localparam logic [2:0] TW_NONE    = 3'd0;
  localparam logic [2:0] TW_CREATE  = 3'd1;
  localparam logic [2:0] TW_SUSPEND = 3'd2;
  localparam logic [2:0] TW_RESUME  = 3'd3;
  localparam logic [2:0] TW_DELETE  = 3'd4;
  localparam logic [2:0] TW_COUNT   = 3'd5;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] count;
  } table_wr_t;

  typedef struct packed {
    logic              present;
    logic              suspended;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] countdown;
  } slot_rd_t;

  typedef struct packed {
    logic               valid;
    logic [KIND_W-1:0]  kind;
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] fired_task;
    logic               last;
  } emit_t;

endpackage

// ===== rtl/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler with its result register.
//
//   channel  dir  handshake                       payload
//   s_axis   in   s_axis_tvalid / s_axis_tready   tuser op; tdata command fields
//   m_axis   out  m_axis_tvalid / m_axis_tready   tuser kind; tdata status, task; tlast
//
// A command is accepted, then its status is issued; a tick is accepted, then walks
// every slot in turn through the shared decrement unit, then issues the final result.
// Backpressure on m_axis holds the issuing cycle until the result register is free, and
// stalls the walk only when a second firing must push out the held one. rst clears the
// task table's present and suspended bits, the sequencer and the result register's
// valid bit; no clearing pass.
module periodic_task_tick_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // op
  input  logic [39:0] s_axis_tdata,   // task_index, period, first_delay, has_handler
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic [7:0]  m_axis_tdata,   // status, fired_task
  output logic        m_axis_tlast
);

  pts_pkg::emit_t                emit;
  pts_pkg::slot_rd_t             rd;
  pts_pkg::table_wr_t            wr;
  logic [pts_pkg::SLOT_W-1:0]    rd_slot;
  logic                          out_free;

  logic [pts_pkg::KIND_W-1:0]    res_kind;
  logic [pts_pkg::STAT_W-1:0]    res_status;
  logic [pts_pkg::INDEX_W-1:0]   res_task;
  logic                          res_last;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  pts_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_index   (s_axis_tdata[2:0]),
    .in_period  (s_axis_tdata[18:3]),
    .in_delay   (s_axis_tdata[34:19]),
    .in_handler (s_axis_tdata[35]),
    .out_free   (out_free),
    .emit       (emit),
    .rd_slot    (rd_slot),
    .rd         (rd),
    .wr         (wr)
  );

  pts_slot_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_slot (rd_slot),
    .rd      (rd),
    .wr      (wr)
  );

  // Load a new result when issued, otherwise drop the old one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      res_kind   <= emit.kind;
      res_status <= emit.status;
      res_task   <= emit.fired_task;
      res_last   <= emit.last;
    end
  end

  assign m_axis_tuser = res_kind;
  assign m_axis_tdata = {3'b000, res_task, res_status};
  assign m_axis_tlast = res_last;

endmodule

// ===== rtl/pts_slot_table.sv =====
// Task slot table: present and suspended bits, period and countdown per slot.
module pts_slot_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pts_pkg::SLOT_W-1:0]        rd_slot,
  output pts_pkg::slot_rd_t                 rd,
  input  pts_pkg::table_wr_t                wr
);

  logic [pts_pkg::TASK_SLOTS-1:0] present;
  logic [pts_pkg::TASK_SLOTS-1:0] suspended;
  logic [pts_pkg::TIME_W-1:0]     period    [pts_pkg::TASK_SLOTS];
  logic [pts_pkg::TIME_W-1:0]     countdown [pts_pkg::TASK_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      suspended <= '0;
    end else begin
      case (wr.op)
        pts_pkg::TW_CREATE: begin
          present[wr.slot]   <= 1'b1;
          suspended[wr.slot] <= 1'b0;
        end
        pts_pkg::TW_SUSPEND: suspended[wr.slot] <= 1'b1;
        pts_pkg::TW_RESUME:  suspended[wr.slot] <= 1'b0;
        pts_pkg::TW_DELETE:  present[wr.slot]   <= 1'b0;
        default: ;
      endcase
    end
  end

  // Period and countdown are only seen once create has written them.
  always_ff @(posedge clk) begin
    case (wr.op)
      pts_pkg::TW_CREATE: begin
        period[wr.slot]    <= wr.period;
        countdown[wr.slot] <= wr.count;
      end
      pts_pkg::TW_COUNT: countdown[wr.slot] <= wr.count;
      default: ;
    endcase
  end

  assign rd.present   = present[rd_slot];
  assign rd.suspended = suspended[rd_slot];
  assign rd.period    = period[rd_slot];
  assign rd.countdown = countdown[rd_slot];

endmodule

// ===== rtl/pts_seq.sv =====
// Sequencer: command handling and the slot walk with one shared decrement unit.
module pts_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pts_pkg::OP_W-1:0]       in_op,
  input  logic [pts_pkg::INDEX_W-1:0]    in_index,
  input  logic [pts_pkg::TIME_W-1:0]     in_period,
  input  logic [pts_pkg::TIME_W-1:0]     in_delay,
  input  logic                           in_handler,
  input  logic                           out_free,
  output pts_pkg::emit_t                 emit,
  output logic [pts_pkg::SLOT_W-1:0]     rd_slot,
  input  pts_pkg::slot_rd_t              rd,
  output pts_pkg::table_wr_t             wr
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMD   = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [pts_pkg::SLOT_W-1:0] LAST_SLOT =
    pts_pkg::SLOT_W'(pts_pkg::TASK_SLOTS - 1);

  logic [1:0]                    state, state_next;
  logic [pts_pkg::SLOT_W-1:0]    idx, idx_next;
  logic                          pend_valid, pend_valid_next;
  logic [pts_pkg::INDEX_W-1:0]   pend_slot, pend_slot_next;

  logic [pts_pkg::OP_W-1:0]      cmd_op;
  logic [pts_pkg::INDEX_W-1:0]   cmd_index;
  logic [pts_pkg::TIME_W-1:0]    cmd_period;
  logic [pts_pkg::TIME_W-1:0]    cmd_delay;
  logic                          cmd_handler;

  logic                          accept;
  logic                          cmd_in_range;
  logic [pts_pkg::SLOT_W-1:0]    cmd_slot;
  logic                          active;
  logic                          fire;
  logic                          blocked;
  logic [pts_pkg::TIME_W-1:0]    sub_in;
  logic [pts_pkg::TIME_W-1:0]    sub_out;
  logic [pts_pkg::STAT_W-1:0]    cmd_status;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign cmd_slot     = pts_pkg::SLOT_W'(cmd_index);
  assign cmd_in_range = 32'(cmd_index) < 32'(pts_pkg::TASK_SLOTS);
  assign rd_slot      = (state == ST_WALK) ? idx : cmd_slot;

  // Shared unit: reload to period - 1 on a firing, otherwise count down.
  assign active  = rd.present && !rd.suspended;
  assign fire    = active && (rd.countdown == '0);
  assign sub_in  = fire ? rd.period : rd.countdown;
  assign sub_out = sub_in - pts_pkg::TIME_W'(1);

  // A second firing must push the held one out before it can be taken.
  assign blocked = fire && pend_valid && !out_free;

  always_comb begin
    if (cmd_op == pts_pkg::OP_CREATE && !cmd_handler) begin
      cmd_status = pts_pkg::STAT_NO_HANDLER;
    end else if (cmd_op == pts_pkg::OP_CREATE && (!cmd_in_range || rd.present)) begin
      cmd_status = pts_pkg::STAT_IN_USE;
    end else begin
      cmd_status = pts_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    emit            = '0;
    wr              = '0;
    wr.op           = pts_pkg::TW_NONE;
    wr.slot         = rd_slot;
    wr.period       = cmd_period;
    wr.count        = cmd_delay;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next      = (in_op == pts_pkg::OP_TICK) ? ST_WALK : ST_CMD;
          idx_next        = '0;
          pend_valid_next = 1'b0;
        end
      end
      ST_CMD: begin
        if (out_free) begin
          emit.valid  = 1'b1;
          emit.kind   = pts_pkg::KIND_STATUS;
          emit.status = cmd_status;
          emit.last   = 1'b1;
          if (cmd_in_range) begin
            case (cmd_op)
              pts_pkg::OP_CREATE: begin
                if (cmd_status == pts_pkg::STAT_OK) begin
                  wr.op = pts_pkg::TW_CREATE;
                end
              end
              pts_pkg::OP_SUSPEND: wr.op = pts_pkg::TW_SUSPEND;
              pts_pkg::OP_RESUME:  wr.op = pts_pkg::TW_RESUME;
              pts_pkg::OP_DELETE:  wr.op = pts_pkg::TW_DELETE;
              default:             wr.op = pts_pkg::TW_NONE;
            endcase
          end
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (!blocked) begin
          if (active) begin
            wr.op    = pts_pkg::TW_COUNT;
            wr.count = sub_out;
          end
          if (fire) begin
            if (pend_valid) begin
              emit.valid      = 1'b1;
              emit.kind       = pts_pkg::KIND_FIRED;
              emit.fired_task = pend_slot;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = pts_pkg::INDEX_W'(idx);
          end
          if (idx == LAST_SLOT) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + pts_pkg::SLOT_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit.valid      = 1'b1;
          emit.kind       = pend_valid ? pts_pkg::KIND_FIRED : pts_pkg::KIND_IDLE;
          emit.fired_task = pend_valid ? pend_slot : '0;
          emit.last       = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot <= pend_slot_next;
    if (accept) begin
      cmd_op      <= in_op;
      cmd_index   <= in_index;
      cmd_period  <= in_period;
      cmd_delay   <= in_delay;
      cmd_handler <= in_handler;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.last |=> state == ST_IDLE)
    else $error("final result did not return the sequencer to idle");

  a_no_emit_blocked: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("result issued while the output register was full");

  a_stall_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK && blocked |-> wr.op == pts_pkg::TW_NONE)
    else $error("slot updated during a stalled walk step");

  a_flush_at_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> idx == LAST_SLOT)
    else $error("walk ended before the last slot");
`endif

endmodule

// ===== bench/tb_periodic_task_tick_scheduler.sv =====
// Testbench for the periodic task tick scheduler: random and directed commands checked per result.
`timescale 1ns / 1ps

module tb_periodic_task_tick_scheduler;

  // Op codes the block treats as no-ops.
  localparam logic [pts_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [pts_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [pts_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_CMDS = 250;
  localparam int QUIET_FROM  = 210;
  localparam int DRAIN_AT    = 120;
  localparam int HOLD_AFTER  = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [pts_pkg::OP_W-1:0]    op;
    logic [pts_pkg::INDEX_W-1:0] slot;
    logic [pts_pkg::TIME_W-1:0]  period;
    logic [pts_pkg::TIME_W-1:0]  delay;
    logic                        handler;
    logic                        drain;    // wait for every result before sending
    logic                        calm;     // no idling from here on
  } sched_cmd_t;

  typedef struct packed {
    logic [pts_pkg::KIND_W-1:0]  kind;
    logic [pts_pkg::STAT_W-1:0]  status;
    logic [pts_pkg::INDEX_W-1:0] fired_task;
    logic                        last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;   // op
  logic [39:0] s_axis_tdata = '0;   // task_index, period, first_delay, has_handler
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;        // kind
  logic [7:0]  m_axis_tdata;        // status, fired_task
  logic        m_axis_tlast;

  periodic_task_tick_scheduler uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  sched_cmd_t    cmd_backlog[$];
  sched_result_t due_results[$];
  sched_cmd_t    offer;

  // Shadow task table.
  logic                       tbl_present   [pts_pkg::TASK_SLOTS];
  logic                       tbl_suspended [pts_pkg::TASK_SLOTS];
  logic [pts_pkg::TIME_W-1:0] tbl_period    [pts_pkg::TASK_SLOTS];
  logic [pts_pkg::TIME_W-1:0] tbl_countdown [pts_pkg::TASK_SLOTS];

  logic in_taken   = 1'b0;
  logic quiet_tail = 1'b0;
  logic hold_sink  = 1'b0;
  logic gap_taken  = 1'b0;
  int   send_gap   = 0;
  int   sink_gap   = 0;
  int   taken_count = 0;
  int   mismatches  = 0;

  function automatic void note_result(logic [pts_pkg::KIND_W-1:0] kind,
                                      logic [pts_pkg::STAT_W-1:0] status,
                                      logic [pts_pkg::INDEX_W-1:0] task_id, logic last);
    sched_result_t r;
    r.kind       = kind;
    r.status     = status;
    r.fired_task = task_id;
    r.last       = last;
    due_results.push_back(r);
  endfunction

  // Update the shadow table and queue the results one command causes.
  function automatic void apply_command(sched_cmd_t c);
    logic [pts_pkg::TASK_SLOTS-1:0] fired;
    int last_slot;
    fired = '0;
    last_slot = -1;
    case (c.op)
      pts_pkg::OP_CREATE: begin
        if (!c.handler) begin
          note_result(pts_pkg::KIND_STATUS, pts_pkg::STAT_NO_HANDLER, '0, 1'b1);
        end else if (tbl_present[c.slot]) begin
          note_result(pts_pkg::KIND_STATUS, pts_pkg::STAT_IN_USE, '0, 1'b1);
        end else begin
          tbl_present[c.slot]   = 1'b1;
          tbl_suspended[c.slot] = 1'b0;
          tbl_period[c.slot]    = c.period;
          tbl_countdown[c.slot] = c.delay;
          note_result(pts_pkg::KIND_STATUS, pts_pkg::STAT_OK, '0, 1'b1);
        end
      end
      pts_pkg::OP_SUSPEND: begin
        tbl_suspended[c.slot] = 1'b1;
        note_result(pts_pkg::KIND_STATUS, pts_pkg::STAT_OK, '0, 1'b1);
      end
      pts_pkg::OP_RESUME: begin
        tbl_suspended[c.slot] = 1'b0;
        note_result(pts_pkg::KIND_STATUS, pts_pkg::STAT_OK, '0, 1'b1);
      end
      pts_pkg::OP_DELETE: begin
        tbl_present[c.slot] = 1'b0;
        note_result(pts_pkg::KIND_STATUS, pts_pkg::STAT_OK, '0, 1'b1);
      end
      pts_pkg::OP_TICK: begin
        for (int i = 0; i < pts_pkg::TASK_SLOTS; i++) begin
          if (tbl_present[i] && !tbl_suspended[i]) begin
            if (tbl_countdown[i] == '0) begin
              tbl_countdown[i] = tbl_period[i] - 16'd1;
              fired[i] = 1'b1;
              last_slot = i;
            end else begin
              tbl_countdown[i] = tbl_countdown[i] - 16'd1;
            end
          end
        end
        if (last_slot < 0) begin
          note_result(pts_pkg::KIND_IDLE, pts_pkg::STAT_OK, '0, 1'b1);
        end else begin
          for (int i = 0; i < pts_pkg::TASK_SLOTS; i++) begin
            if (fired[i])
              note_result(pts_pkg::KIND_FIRED, pts_pkg::STAT_OK,
                          pts_pkg::INDEX_W'(i), i == last_slot);
          end
        end
      end
      default: note_result(pts_pkg::KIND_STATUS, pts_pkg::STAT_OK, '0, 1'b1);
    endcase
  endfunction

  function automatic void queue_cmd(logic [pts_pkg::OP_W-1:0] op,
                                    logic [pts_pkg::INDEX_W-1:0] slot,
                                    logic [pts_pkg::TIME_W-1:0] period,
                                    logic [pts_pkg::TIME_W-1:0] delay,
                                    logic handler);
    sched_cmd_t c;
    c.op      = op;
    c.slot    = slot;
    c.period  = period;
    c.delay   = delay;
    c.handler = handler;
    c.drain   = 1'b0;
    c.calm    = 1'b0;
    cmd_backlog.push_back(c);
  endfunction

  function automatic logic [pts_pkg::TIME_W-1:0] pick_time();
    if ($urandom_range(0, 4) == 0) return pts_pkg::TIME_W'($urandom_range(0, 65535));
    return pts_pkg::TIME_W'($urandom_range(0, 5));
  endfunction

  // Sender: hold an offered transaction until it is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !in_taken) begin
      end else if (send_gap != 0) begin
        send_gap = send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() == 0 ||
                   (cmd_backlog[0].drain && due_results.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (!cmd_backlog[0].calm && !gap_taken && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 11);
        gap_taken = 1'b1;
        s_axis_tvalid <= 1'b0;
      end else begin
        offer = cmd_backlog.pop_front();
        gap_taken = 1'b0;
        if (offer.calm) quiet_tail <= 1'b1;
        s_axis_tuser  <= offer.op;
        s_axis_tdata  <= {4'b0, offer.handler, offer.delay, offer.period, offer.slot};
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap = sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (taken_count < HOLD_AFTER) @(posedge clk);
    hold_sink = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_sink = 1'b0;
  end

  // Predict on input transactions, check output transactions.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_command(offer);
        taken_count <= taken_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind       = m_axis_tuser;
        got.status     = m_axis_tdata[1:0];
        got.fired_task = m_axis_tdata[4:2];
        got.last       = m_axis_tlast;
        if (due_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d status %0d task %0d last %0d",
                     got.kind, got.status, got.fired_task, got.last);
        end else begin
          want = due_results.pop_front();
          if (got != want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display({"mismatch: expected kind %0d status %0d task %0d last %0d, ",
                        "got kind %0d status %0d task %0d last %0d"},
                       want.kind, want.status, want.fired_task, want.last,
                       got.kind, got.status, got.fired_task, got.last);
          end
        end
      end
    end
  end

  initial begin
    sched_cmd_t c;
    int r;
    for (int i = 0; i < pts_pkg::TASK_SLOTS; i++) begin
      tbl_present[i]   = 1'b0;
      tbl_suspended[i] = 1'b0;
      tbl_period[i]    = '0;
      tbl_countdown[i] = '0;
    end

    // Empty table, create failures, wrap of a zero period, suspend of an absent slot.
    queue_cmd(pts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(pts_pkg::OP_CREATE, 3'd0, 16'd5, 16'd5, 1'b0);
    queue_cmd(pts_pkg::OP_CREATE, 3'd0, 16'd0, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_CREATE, 3'd0, 16'd3, 16'd3, 1'b1);
    queue_cmd(pts_pkg::OP_CREATE, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_cmd(pts_pkg::OP_SUSPEND, 3'd3, 16'd0, 16'd0, 1'b0);
    queue_cmd(pts_pkg::OP_CREATE, 3'd3, 16'd1, 16'd1, 1'b1);
    queue_cmd(pts_pkg::OP_RESUME, 3'd5, 16'hFFFF, 16'hFFFF, 1'b1);
    repeat (3) queue_cmd(pts_pkg::OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
    // Fill every slot so one tick fires all eight.
    queue_cmd(pts_pkg::OP_CREATE, 3'd1, 16'd1, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_CREATE, 3'd2, 16'd1, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_CREATE, 3'd4, 16'd1, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_CREATE, 3'd5, 16'd1, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_CREATE, 3'd6, 16'd1, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_DELETE, 3'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(pts_pkg::OP_DELETE, 3'd7, 16'd0, 16'd0, 1'b0);
    queue_cmd(pts_pkg::OP_CREATE, 3'd0, 16'd1, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_CREATE, 3'd7, 16'd1, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(OP_SPARE_5, 3'd2, 16'd9, 16'd9, 1'b1);
    queue_cmd(OP_SPARE_6, 3'd4, 16'd0, 16'd0, 1'b0);
    queue_cmd(OP_SPARE_7, 3'd6, 16'hFFFF, 16'd0, 1'b1);
    queue_cmd(pts_pkg::OP_SUSPEND, 3'd2, 16'd0, 16'd0, 1'b0);
    queue_cmd(pts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0, 1'b0);
    queue_cmd(pts_pkg::OP_RESUME, 3'd2, 16'd0, 16'd0, 1'b0);

    // Random part: mostly creates and ticks on short periods so slots keep firing.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      c.slot    = pts_pkg::INDEX_W'($urandom_range(0, 7));
      c.period  = pick_time();
      c.delay   = pick_time();
      c.handler = ($urandom_range(0, 9) != 0);
      if (r < 45)      c.op = pts_pkg::OP_TICK;
      else if (r < 70) c.op = pts_pkg::OP_CREATE;
      else if (r < 78) c.op = pts_pkg::OP_SUSPEND;
      else if (r < 86) c.op = pts_pkg::OP_RESUME;
      else if (r < 96) c.op = pts_pkg::OP_DELETE;
      else if (r < 97) c.op = OP_SPARE_5;
      else if (r < 98) c.op = OP_SPARE_6;
      else             c.op = OP_SPARE_7;
      c.drain = (n == DRAIN_AT);
      c.calm  = (n >= QUIET_FROM);
      cmd_backlog.push_back(c);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmd_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk);
    repeat (pts_pkg::TASK_SLOTS + 10) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pts_pkg.sv
rtl/pts_slot_table.sv
rtl/pts_seq.sv
rtl/periodic_task_tick_scheduler.sv
bench/tb_periodic_task_tick_scheduler.sv
